/* rtl/otg_pkg.sv */
// Shared types and constants for the overlapping tile grid generator.
package otg_pkg;

  localparam int DIM_W       = 16;
  localparam int MAX_COLUMNS = 8;
  localparam int MAX_ROWS    = 8;
  localparam int CNT_W       = 4;
  localparam int COL_IDX_W   = $clog2(MAX_COLUMNS);
  localparam int ROW_IDX_W   = $clog2(MAX_ROWS);
  localparam int RESULT_CAP  = 64;
  localparam int LIMIT_W     = 7;
  localparam int NUM_W       = 6;
  localparam int OVL_W       = 16;
  localparam int HALF_W      = OVL_W - 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int STEP_W      = $clog2(DIM_W + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLUMNS   = 2'd0,
    CFG_GRID_ROWS      = 2'd1,
    CFG_OVERLAP_PIXELS = 2'd2,
    CFG_TILE_LIMIT     = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV_W,
    FE_DIV_H,
    FE_PUSH
  } fe_state_t;

  // Effective settings after clamping.
  typedef struct packed {
    logic [CNT_W-1:0]   cols;
    logic [CNT_W-1:0]   rows;
    logic [LIMIT_W-1:0] limit;
    logic [HALF_W-1:0]  half;
  } grid_cfg_t;

  // One classified request, passed from front to back.
  typedef struct packed {
    logic [DIM_W-1:0]   img_w;
    logic [DIM_W-1:0]   img_h;
    logic [DIM_W-1:0]   cell_w;
    logic [DIM_W-1:0]   cell_h;
    grid_cfg_t          cfg;
    logic               empty;
  } job_t;

endpackage

/* rtl/otg_in_if.sv */
// Request channel: image size with valid/ready handshake.
interface otg_in_if;
  logic                     valid;
  logic                     ready;
  logic [otg_pkg::DIM_W-1:0] image_width;
  logic [otg_pkg::DIM_W-1:0] image_height;

  modport source (output valid, output image_width, output image_height, input ready);
  modport sink   (input valid, input image_width, input image_height, output ready);
endinterface

/* rtl/otg_out_if.sv */
// Tile channel: one tile rectangle per beat with valid/ready handshake.
interface otg_out_if;
  logic                      valid;
  logic                      ready;
  logic [otg_pkg::DIM_W-1:0] tile_x;
  logic [otg_pkg::DIM_W-1:0] tile_y;
  logic [otg_pkg::DIM_W-1:0] tile_width;
  logic [otg_pkg::DIM_W-1:0] tile_height;
  logic [otg_pkg::NUM_W-1:0] tile_number;
  logic                      no_tiles;
  logic                      last_tile;

  modport source (output valid, output tile_x, output tile_y, output tile_width,
                  output tile_height, output tile_number, output no_tiles,
                  output last_tile, input ready);
  modport sink   (input valid, input tile_x, input tile_y, input tile_width,
                  input tile_height, input tile_number, input no_tiles,
                  input last_tile, output ready);
endinterface

/* rtl/overlapping_tile_grid_generator.sv */
// Top level of the overlapping tile grid generator: settings, front, queue, back.
//
// Each request beat carries an image width and height; the block answers with
// the tiles of a grid_columns x grid_rows grid in row-major order, each base
// cell grown by half the overlap on every side and clipped to the image, and
// stops after tile_limit tiles. The final beat of a run has last_tile set. A
// zero size, or an image narrower or shorter than the grid, gives a single
// beat with no_tiles and last_tile set. The front end holds each request
// through two 16-step serial divisions by the column and row counts in one
// shared divider, then a push state that queues the job, and only then
// returns to idle, so a new request beat is taken only after the job is queued.
// The back end loads a queued job into its registers and then emits one
// tile per cycle while the receiver keeps up. With the two-entry job queue
// the front end works on the next request while the back end is still
// emitting the current one; a full queue holds the front end and a stalled
// receiver holds the back end. Settings are sampled as a request is taken;
// write them only while the block is idle.
module overlapping_tile_grid_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [otg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [otg_pkg::CFG_DATA_W-1:0]  cfg_data,
  otg_in_if.sink                          in_ch,
  otg_out_if.source                       out_ch
);

  logic [otg_pkg::CNT_W-1:0]   grid_columns_r;
  logic [otg_pkg::CNT_W-1:0]   grid_rows_r;
  logic [otg_pkg::OVL_W-1:0]   overlap_r;
  logic [otg_pkg::LIMIT_W-1:0] tile_limit_r;
  otg_pkg::grid_cfg_t          cfg;

  logic          push, full, pop, empty;
  otg_pkg::job_t push_job, pop_job;

  // Settings registers; hold their value between writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_columns_r <= otg_pkg::CNT_W'(3);
      grid_rows_r    <= otg_pkg::CNT_W'(3);
      overlap_r      <= '0;
      tile_limit_r   <= otg_pkg::LIMIT_W'(otg_pkg::RESULT_CAP);
    end else if (cfg_we) begin
      unique case (cfg_index)
        otg_pkg::CFG_GRID_COLUMNS:   grid_columns_r <= cfg_data[otg_pkg::CNT_W-1:0];
        otg_pkg::CFG_GRID_ROWS:      grid_rows_r    <= cfg_data[otg_pkg::CNT_W-1:0];
        otg_pkg::CFG_OVERLAP_PIXELS: overlap_r      <= cfg_data[otg_pkg::OVL_W-1:0];
        otg_pkg::CFG_TILE_LIMIT:     tile_limit_r   <= cfg_data[otg_pkg::LIMIT_W-1:0];
        default:                     overlap_r      <= overlap_r;
      endcase
    end
  end

  // Clamp: a zero count acts as one, a large count saturates at the grid maximum,
  // a zero or oversized limit acts as the full result cap.
  always_comb begin
    if (grid_columns_r == '0) begin
      cfg.cols = otg_pkg::CNT_W'(1);
    end else if (grid_columns_r > otg_pkg::CNT_W'(otg_pkg::MAX_COLUMNS)) begin
      cfg.cols = otg_pkg::CNT_W'(otg_pkg::MAX_COLUMNS);
    end else begin
      cfg.cols = grid_columns_r;
    end
    if (grid_rows_r == '0) begin
      cfg.rows = otg_pkg::CNT_W'(1);
    end else if (grid_rows_r > otg_pkg::CNT_W'(otg_pkg::MAX_ROWS)) begin
      cfg.rows = otg_pkg::CNT_W'(otg_pkg::MAX_ROWS);
    end else begin
      cfg.rows = grid_rows_r;
    end
    if (tile_limit_r == '0 || tile_limit_r > otg_pkg::LIMIT_W'(otg_pkg::RESULT_CAP)) begin
      cfg.limit = otg_pkg::LIMIT_W'(otg_pkg::RESULT_CAP);
    end else begin
      cfg.limit = tile_limit_r;
    end
    cfg.half = overlap_r[otg_pkg::OVL_W-1:1];
  end

  otg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg),
    .push     (push),
    .push_job (push_job),
    .full     (full)
  );

  otg_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  otg_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .empty   (empty),
    .pop_job (pop_job),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

/* rtl/otg_divider.sv */
// Restoring divider: one quotient bit per cycle, small divisor.
module otg_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [otg_pkg::DIM_W-1:0]  dividend,
  input  logic [otg_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [otg_pkg::DIM_W-1:0]  quotient
);

  logic [otg_pkg::DIM_W-1:0]  quo_r,  quo_nxt;
  logic [otg_pkg::CNT_W-1:0]  rem_r,  rem_nxt;
  logic [otg_pkg::CNT_W-1:0]  div_r,  div_nxt;
  logic [otg_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [otg_pkg::CNT_W:0]    trial;
  logic                       fits;

  always_comb begin
    trial    = {rem_r, quo_r[otg_pkg::DIM_W-1]};
    fits     = trial >= {1'b0, div_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[otg_pkg::DIM_W-2:0], fits};
      rem_nxt = fits ? otg_pkg::CNT_W'(trial - {1'b0, div_r}) : trial[otg_pkg::CNT_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == otg_pkg::STEP_W'(otg_pkg::DIM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* rtl/otg_front.sv */
// Front end: accept a request, work out the base cell, classify, queue the job.
module otg_front (
  input  logic               clk,
  input  logic               rst_n,
  otg_in_if.sink             in_ch,
  input  otg_pkg::grid_cfg_t cfg,
  output logic               push,
  output otg_pkg::job_t      push_job,
  input  logic               full
);

  otg_pkg::fe_state_t state_r, state_nxt;

  logic [otg_pkg::DIM_W-1:0] img_w_r, img_h_r, cell_w_r, cell_h_r;
  otg_pkg::grid_cfg_t        cfg_r;
  logic                      div_start, div_done;
  logic [otg_pkg::DIM_W-1:0] div_dividend, div_quotient;
  logic [otg_pkg::CNT_W-1:0] div_divisor;
  logic                      accept;

  otg_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      otg_pkg::FE_IDLE:  if (in_ch.valid) state_nxt = otg_pkg::FE_DIV_W;
      otg_pkg::FE_DIV_W: if (div_done)    state_nxt = otg_pkg::FE_DIV_H;
      otg_pkg::FE_DIV_H: if (div_done)    state_nxt = otg_pkg::FE_PUSH;
      otg_pkg::FE_PUSH:  if (!full)       state_nxt = otg_pkg::FE_IDLE;
      default:                            state_nxt = otg_pkg::FE_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = 1'b0;
    div_start    = 1'b0;
    div_dividend = img_h_r;
    div_divisor  = cfg_r.rows;
    push         = 1'b0;
    unique case (state_r)
      otg_pkg::FE_IDLE: begin
        in_ch.ready  = 1'b1;
        div_start    = in_ch.valid;
        div_dividend = in_ch.image_width;
        div_divisor  = cfg.cols;
      end
      otg_pkg::FE_DIV_W: div_start = div_done;
      otg_pkg::FE_DIV_H: div_start = 1'b0;
      otg_pkg::FE_PUSH:  push      = !full;
      default:           push      = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= otg_pkg::FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (accept) begin
      img_w_r <= in_ch.image_width;
      img_h_r <= in_ch.image_height;
      cfg_r   <= cfg;
    end
    if (div_done && state_r == otg_pkg::FE_DIV_W) cell_w_r <= div_quotient;
    if (div_done && state_r == otg_pkg::FE_DIV_H) cell_h_r <= div_quotient;
  end

  always_comb begin
    push_job.img_w  = img_w_r;
    push_job.img_h  = img_h_r;
    push_job.cell_w = cell_w_r;
    push_job.cell_h = cell_h_r;
    push_job.cfg    = cfg_r;
    push_job.empty  = (img_w_r == '0) || (img_h_r == '0) ||
                      (cell_w_r == '0) || (cell_h_r == '0);
  end

endmodule

/* rtl/otg_job_fifo.sv */
// Two-entry job queue between front and back ends.
module otg_job_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  otg_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output otg_pkg::job_t pop_job,
  output logic          empty
);

  otg_pkg::job_t slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    fill_r,   fill_nxt;

  assign full    = fill_r == 2'd2;
  assign empty   = fill_r == 2'd0;
  assign pop_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

endmodule

/* rtl/otg_back.sv */
// Back end: walk the grid of one job and emit one tile per beat.
module otg_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          empty,
  input  otg_pkg::job_t pop_job,
  output logic          pop,
  otg_out_if.source     out_ch
);

  otg_pkg::job_t                 job_r;
  logic                          active_r, active_nxt;
  logic [otg_pkg::COL_IDX_W-1:0] col_r, col_nxt;
  logic [otg_pkg::ROW_IDX_W-1:0] row_r, row_nxt;
  logic [otg_pkg::DIM_W-1:0]     bx_r, bx_nxt, by_r, by_nxt;
  logic [otg_pkg::LIMIT_W-1:0]   count_r, count_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic [otg_pkg::DIM_W-1:0]   x_r, y_r, w_r, h_r;
  logic [otg_pkg::NUM_W-1:0]   num_r;
  logic                        none_r, last_r;

  logic [otg_pkg::DIM_W-1:0]   half, x0, y0, x1, y1;
  logic [otg_pkg::DIM_W+1:0]   x1_full, y1_full;
  logic                        col_end, row_end, limit_hit, last, emit;

  assign half = otg_pkg::DIM_W'(job_r.cfg.half);
  assign emit = active_r && (!out_valid_r || out_ch.ready);
  assign pop  = !active_r && !empty;

  always_comb begin
    x0 = (bx_r > half) ? bx_r - half : '0;
    y0 = (by_r > half) ? by_r - half : '0;
    x1_full = {2'b00, bx_r} + {2'b00, job_r.cell_w} + {2'b00, half};
    y1_full = {2'b00, by_r} + {2'b00, job_r.cell_h} + {2'b00, half};
    x1 = (x1_full > {2'b00, job_r.img_w}) ? job_r.img_w : x1_full[otg_pkg::DIM_W-1:0];
    y1 = (y1_full > {2'b00, job_r.img_h}) ? job_r.img_h : y1_full[otg_pkg::DIM_W-1:0];
    col_end   = (otg_pkg::CNT_W'(col_r) + 1'b1) == job_r.cfg.cols;
    row_end   = (otg_pkg::CNT_W'(row_r) + 1'b1) == job_r.cfg.rows;
    limit_hit = (count_r + 1'b1) == job_r.cfg.limit;
    last      = job_r.empty || limit_hit || (col_end && row_end);
  end

  // Grid walk: advance column, wrap to next row, stop on the last tile.
  always_comb begin
    active_nxt = active_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    bx_nxt     = bx_r;
    by_nxt     = by_r;
    count_nxt  = count_r;
    if (pop) begin
      active_nxt = 1'b1;
      col_nxt    = '0;
      row_nxt    = '0;
      bx_nxt     = '0;
      by_nxt     = '0;
      count_nxt  = '0;
    end else if (emit) begin
      count_nxt = count_r + 1'b1;
      if (last) begin
        active_nxt = 1'b0;
      end else if (col_end) begin
        col_nxt = '0;
        bx_nxt  = '0;
        row_nxt = row_r + 1'b1;
        by_nxt  = by_r + job_r.cell_h;
      end else begin
        col_nxt = col_r + 1'b1;
        bx_nxt  = bx_r + job_r.cell_w;
      end
    end
    out_valid_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    bx_r    <= bx_nxt;
    by_r    <= by_nxt;
    count_r <= count_nxt;
    if (pop) job_r <= pop_job;
    if (emit) begin
      if (job_r.empty) begin
        x_r   <= '0;
        y_r   <= '0;
        w_r   <= '0;
        h_r   <= '0;
        num_r <= '0;
      end else begin
        x_r   <= x0;
        y_r   <= y0;
        w_r   <= x1 - x0;
        h_r   <= y1 - y0;
        num_r <= count_r[otg_pkg::NUM_W-1:0];
      end
      none_r <= job_r.empty;
      last_r <= last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.tile_x      = x_r;
  assign out_ch.tile_y      = y_r;
  assign out_ch.tile_width  = w_r;
  assign out_ch.tile_height = h_r;
  assign out_ch.tile_number = num_r;
  assign out_ch.no_tiles    = none_r;
  assign out_ch.last_tile   = last_r;

endmodule

/* verif/otg_tile_checker.sv */
// Scoreboard for the tile grid generator: predicts the tiles of each request and checks every beat.
module otg_tile_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [otg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [otg_pkg::CFG_DATA_W-1:0] cfg_data,
  otg_in_if                              in_mon,
  otg_out_if                             out_mon,
  output int                             fail_count,
  output int                             tiles_pending,
  output int                             tiles_checked
);

  typedef struct packed {
    logic [otg_pkg::DIM_W-1:0] tile_x;
    logic [otg_pkg::DIM_W-1:0] tile_y;
    logic [otg_pkg::DIM_W-1:0] tile_width;
    logic [otg_pkg::DIM_W-1:0] tile_height;
    logic [otg_pkg::NUM_W-1:0] tile_number;
    logic                      no_tiles;
    logic                      last_tile;
  } tile_beat_t;

  // Local copy of the settings and of the last request's grid.
  logic [otg_pkg::CNT_W-1:0]   grid_columns   = 4'd3;
  logic [otg_pkg::CNT_W-1:0]   grid_rows      = 4'd3;
  logic [otg_pkg::OVL_W-1:0]   overlap_pixels = '0;
  logic [otg_pkg::LIMIT_W-1:0] tile_limit     = 7'd64;
  logic [otg_pkg::DIM_W-1:0]   base_cell_w    = '0;
  logic [otg_pkg::DIM_W-1:0]   base_cell_h    = '0;

  tile_beat_t expected_tiles[$];
  int mismatches = 0;
  int checked    = 0;

  task automatic predict_request(input logic [otg_pkg::DIM_W-1:0] img_w,
                                 input logic [otg_pkg::DIM_W-1:0] img_h);
    int unsigned cols, rows, lim, half, total, count;
    int unsigned bx, by, x0, y0, x1, y1;
    tile_beat_t t;
    cols = (grid_columns == 0) ? 1 :
           (grid_columns > otg_pkg::MAX_COLUMNS) ? otg_pkg::MAX_COLUMNS : grid_columns;
    rows = (grid_rows == 0) ? 1 :
           (grid_rows > otg_pkg::MAX_ROWS) ? otg_pkg::MAX_ROWS : grid_rows;
    lim  = (tile_limit == 0 || tile_limit > otg_pkg::RESULT_CAP) ?
           otg_pkg::RESULT_CAP : tile_limit;
    half = 32'(overlap_pixels >> 1);
    base_cell_w = otg_pkg::DIM_W'(img_w / cols);
    base_cell_h = otg_pkg::DIM_W'(img_h / rows);
    t = '0;
    if (img_w == 0 || img_h == 0 || base_cell_w == 0 || base_cell_h == 0) begin
      t.no_tiles  = 1'b1;
      t.last_tile = 1'b1;
      expected_tiles.push_back(t);
    end else begin
      total = cols * rows;
      if (total > lim) total = lim;
      count = 0;
      for (int r = 0; r < rows; r++) begin
        for (int c = 0; c < cols; c++) begin
          if (count < total) begin
            bx = c * base_cell_w;
            by = r * base_cell_h;
            x0 = (bx > half) ? bx - half : 0;
            y0 = (by > half) ? by - half : 0;
            x1 = bx + base_cell_w + half;
            y1 = by + base_cell_h + half;
            if (x1 > img_w) x1 = img_w;
            if (y1 > img_h) y1 = img_h;
            t.tile_x      = x0[otg_pkg::DIM_W-1:0];
            t.tile_y      = y0[otg_pkg::DIM_W-1:0];
            t.tile_width  = otg_pkg::DIM_W'(x1 - x0);
            t.tile_height = otg_pkg::DIM_W'(y1 - y0);
            t.tile_number = count[otg_pkg::NUM_W-1:0];
            t.no_tiles    = 1'b0;
            t.last_tile   = (count == total - 1);
            expected_tiles.push_back(t);
            count++;
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    tile_beat_t want;
    logic       bad;
    if (!rst_n) begin
      grid_columns   = 4'd3;
      grid_rows      = 4'd3;
      overlap_pixels = '0;
      tile_limit     = 7'd64;
      expected_tiles.delete();
    end else begin
      if (cfg_we) begin
        case (otg_pkg::cfg_reg_t'(cfg_index))
          otg_pkg::CFG_GRID_COLUMNS:   grid_columns   = cfg_data[otg_pkg::CNT_W-1:0];
          otg_pkg::CFG_GRID_ROWS:      grid_rows      = cfg_data[otg_pkg::CNT_W-1:0];
          otg_pkg::CFG_OVERLAP_PIXELS: overlap_pixels = cfg_data[otg_pkg::OVL_W-1:0];
          otg_pkg::CFG_TILE_LIMIT:     tile_limit     = cfg_data[otg_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        predict_request(in_mon.image_width, in_mon.image_height);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_tiles.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected tile beat: x=%0d y=%0d w=%0d h=%0d n=%0d empty=%0d last=%0d",
                     out_mon.tile_x, out_mon.tile_y, out_mon.tile_width, out_mon.tile_height,
                     out_mon.tile_number, out_mon.no_tiles, out_mon.last_tile);
        end else begin
          want = expected_tiles.pop_front();
          checked++;
          bad = (out_mon.tile_x !== want.tile_x) || (out_mon.tile_y !== want.tile_y) ||
                (out_mon.tile_width !== want.tile_width) ||
                (out_mon.tile_height !== want.tile_height) ||
                (out_mon.tile_number !== want.tile_number) ||
                (out_mon.no_tiles !== want.no_tiles) || (out_mon.last_tile !== want.last_tile);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("tile beat %0d differs: expected x=%0d y=%0d w=%0d h=%0d n=%0d e=%0d l=%0d,",
                     checked, want.tile_x, want.tile_y, want.tile_width, want.tile_height,
                     want.tile_number, want.no_tiles, want.last_tile);
              $display(" got x=%0d y=%0d w=%0d h=%0d n=%0d e=%0d l=%0d",
                       out_mon.tile_x, out_mon.tile_y, out_mon.tile_width,
                       out_mon.tile_height, out_mon.tile_number, out_mon.no_tiles,
                       out_mon.last_tile);
            end
          end
        end
      end
    end
    fail_count    <= mismatches;
    tiles_pending <= expected_tiles.size();
    tiles_checked <= checked;
  end

endmodule

/* verif/overlapping_tile_grid_generator_tb.sv */
// Stimulus and verdict for the overlapping tile grid generator, with the scoreboard beside it.
module overlapping_tile_grid_generator_tb;

  // Beat-free cycles tolerated before the run is declared hung. The slowest
  // legal gap is a request's two serial divisions plus the
  // longest receiver stall and sender gap, so this is far beyond it.
  localparam int WATCHDOG_LIMIT = 2000;
  // Quiet cycles after the last tile: one full front-end pass plus a full run.
  localparam int TAIL_CYCLES = 120;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_RANDOM,
    RX_PERIODIC,
    RX_BURSTY
  } rx_mode_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [otg_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [otg_pkg::CFG_DATA_W-1:0] cfg_data;

  otg_in_if  in_ch ();
  otg_out_if out_ch ();

  int fail_count;
  int tiles_pending;
  int tiles_checked;

  int requests_sent    = 0;
  int settings_applied = 0;
  int burst_left       = 0;

  overlapping_tile_grid_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  otg_tile_checker scoreboard (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .tiles_pending (tiles_pending),
    .tiles_checked (tiles_checked)
  );

  always #6 clk = ~clk;

  // Receiver: switch between free-running, random, periodic and bursty
  // stalling, each mode held for a random stretch, so back-pressure lands on every phase
  // of a run, including its first and last tile.
  rx_mode_t rx_mode       = RX_FREE;
  int       rx_mode_left  = 0;
  int       rx_stall_left = 0;
  int       rx_tick       = 0;

  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 200);
    end else begin
      rx_mode_left--;
    end
    rx_tick++;
    case (rx_mode)
      RX_FREE:     out_ch.ready <= 1'b1;
      RX_RANDOM:   out_ch.ready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: out_ch.ready <= ((rx_tick % 5) < 3);
      default: begin
        // Hold ready low for a stretch now and then, otherwise take every beat.
        if (rx_stall_left > 0) begin
          out_ch.ready <= 1'b0;
          rx_stall_left--;
        end else begin
          out_ch.ready <= 1'b1;
          if ($urandom_range(0, 9) == 0) rx_stall_left = $urandom_range(1, 12);
        end
      end
    endcase
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("no beat moved for %0d cycles, %0d tiles still awaited",
             WATCHDOG_LIMIT, tiles_pending);
    $display("overlapping_tile_grid_generator: mismatch");
    $finish;
  end

  // Offer one request beat and hold it until taken. The sender runs in
  // bursts: when a burst is spent, drop valid for a short gap first.
  task automatic send_request(input logic [otg_pkg::DIM_W-1:0] w,
                              input logic [otg_pkg::DIM_W-1:0] h);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      // Now and then a long burst, so stretches without sender idling occur.
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_ch.valid        <= 1'b1;
    in_ch.image_width  <= w;
    in_ch.image_height <= h;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    requests_sent++;
  endtask

  // Drop valid and wait until every predicted tile has come out, then wait on
  // so the block is fully idle before the settings change.
  task automatic settle_block;
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tiles_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers back to back, one per cycle.
  task automatic apply_settings(input logic [otg_pkg::CFG_DATA_W-1:0] cols,
                                input logic [otg_pkg::CFG_DATA_W-1:0] rows,
                                input logic [otg_pkg::CFG_DATA_W-1:0] overlap,
                                input logic [otg_pkg::CFG_DATA_W-1:0] limit);
    otg_pkg::cfg_reg_t              order [4];
    logic [otg_pkg::CFG_DATA_W-1:0] value [4];
    order = '{otg_pkg::CFG_GRID_COLUMNS, otg_pkg::CFG_GRID_ROWS,
              otg_pkg::CFG_OVERLAP_PIXELS, otg_pkg::CFG_TILE_LIMIT};
    value = '{cols, rows, overlap, limit};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= value[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Mostly small sizes so the grid is often wider than the image; some full
  // range and the extremes.
  function automatic logic [otg_pkg::DIM_W-1:0] pick_dimension();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return '0;
    else if (sel < 30) return otg_pkg::DIM_W'($urandom_range(1, 20));
    else if (sel < 70) return otg_pkg::DIM_W'($urandom_range(1, 1000));
    else if (sel < 95) return otg_pkg::DIM_W'($urandom_range(0, 65535));
    else return '1;
  endfunction

  initial begin
    logic [31:0]                    junk;
    logic [otg_pkg::CFG_DATA_W-1:0] cols, rows, overlap, limit;
    int                             sel;
    int                             items;

    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= otg_pkg::CFG_GRID_COLUMNS;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.image_width  <= '0;
    in_ch.image_height <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings (3x3, no overlap, limit 64): empty cases first, then
    // the smallest grid that works, an ordinary one and the largest image.
    send_request(16'd0, 16'd0);
    send_request(16'd0, 16'd100);
    send_request(16'd100, 16'd0);
    send_request(16'd2, 16'd5);
    send_request(16'd3, 16'd3);
    send_request(16'd100, 16'd90);
    send_request(16'hFFFF, 16'hFFFF);

    // Largest grid with the largest overlap: every tile clips to the image.
    settle_block();
    apply_settings(16'd8, 16'd8, 16'hFFFF, 16'd64);
    send_request(16'hFFFF, 16'hFFFF);
    send_request(16'd64, 16'd64);
    send_request(16'd8, 16'd8);
    send_request(16'd7, 16'd100);

    // Zero counts stand for one; a zero limit stands for sixty-four.
    settle_block();
    apply_settings(16'd0, 16'd0, 16'd1, 16'd0);
    send_request(16'd1, 16'd1);
    send_request(16'hFFFF, 16'd1);

    // Counts above the maximum saturate; a limit of one cuts the run short.
    settle_block();
    apply_settings(16'd15, 16'd9, 16'd10, 16'd1);
    send_request(16'd800, 16'd600);
    send_request(16'd16, 16'd16);

    // Single column; a limit above sixty-four stands for sixty-four.
    settle_block();
    apply_settings(16'd1, 16'd8, 16'd2, 16'd127);
    send_request(16'd1000, 16'd8);
    send_request(16'd1000, 16'd7);

    // Upper data bits beyond each register's width are dropped.
    settle_block();
    apply_settings(16'hFFF5, 16'h0007, 16'hFFFE, 16'hFF8A);
    send_request(16'd12345, 16'd54321);
    send_request(16'd40, 16'd70);

    // Random settings, each followed by a stretch of random requests.
    repeat (12) begin
      settle_block();
      junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
      sel  = $urandom_range(0, 4);
      cols = {junk[11:0], (sel == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8))};
      sel  = $urandom_range(0, 4);
      rows = {junk[23:12], (sel == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8))};
      case ($urandom_range(0, 3))
        0:       overlap = '0;
        1:       overlap = otg_pkg::CFG_DATA_W'($urandom_range(0, 64));
        2:       overlap = otg_pkg::CFG_DATA_W'($urandom);
        default: overlap = '1;
      endcase
      case ($urandom_range(0, 3))
        0:       limit = 16'd1;
        1:       limit = 16'd64;
        2:       limit = {junk[31:23], 7'($urandom_range(0, 127))};
        default: limit = otg_pkg::CFG_DATA_W'($urandom_range(1, 20));
      endcase
      apply_settings(cols, rows, overlap, limit);
      items = $urandom_range(18, 42);
      repeat (items) send_request(pick_dimension(), pick_dimension());
    end

    settle_block();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests under %0d written settings plus reset values",
             requests_sent, settings_applied);
    $display("%0d tile beats checked, %0d failures", tiles_checked, fail_count);
    if (fail_count == 0 && tiles_pending == 0) begin
      $display("overlapping_tile_grid_generator: match");
    end else begin
      $display("overlapping_tile_grid_generator: mismatch");
    end
    $finish;
  end

endmodule

/* overlapping_tile_grid_generator.f */
rtl/otg_pkg.sv
rtl/otg_in_if.sv
rtl/otg_out_if.sv
rtl/otg_divider.sv
rtl/otg_front.sv
rtl/otg_job_fifo.sv
rtl/otg_back.sv
rtl/overlapping_tile_grid_generator.sv
verif/otg_tile_checker.sv
verif/overlapping_tile_grid_generator_tb.sv
